### hw/rtl/sha256_message_padder_assert.svh
// Assertion macros for the SHA-256 message padder.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef SHA256_MESSAGE_PADDER_ASSERT_SVH
`define SHA256_MESSAGE_PADDER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHAPAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shapad: implication check failed");
`define SHAPAD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shapad: next-cycle check failed");
`else
`define SHAPAD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SHAPAD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/shapad_pkg.sv
// Shared types and constants for the SHA-256 message padder.
// No dependencies.
`timescale 1ns / 1ps

package shapad_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned CountBits = 64;
  localparam int unsigned PosBits   = 6;
  localparam int unsigned WidxBits  = 4;

  localparam logic       CMD_DATA = 1'b0;
  localparam logic       CMD_END  = 1'b1;
  localparam logic [7:0] PadByte  = 8'h80;

  // last word index before the two length words
  localparam logic [WidxBits-1:0] LastFillIdx = 4'd13;
  localparam logic [WidxBits-1:0] LastWordIdx = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LEN_HI,
    ST_LEN_LO
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DATA,
    OP_SEP,
    OP_FILL,
    OP_LEN_HI,
    OP_LEN_LO
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic fill_done;
  } dp_status_t;

endpackage

### hw/rtl/shapad_if.sv
// Handshake channels of the SHA-256 message padder: byte items in, word items out.
// No dependencies.
`timescale 1ns / 1ps

interface shapad_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface shapad_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_word;
  logic        block_end;
  logic        message_end;

  modport source (output valid, output block_word, output block_end,
                  output message_end, input ready);
  modport sink   (input valid, input block_word, input block_end,
                  input message_end, output ready);
endinterface

### hw/rtl/shapad_datapath.sv
// Datapath of the SHA-256 message padder: bit count, block position, word packer
// and output register. Depends on shapad_pkg and shapad_if.
`timescale 1ns / 1ps

module shapad_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  shapad_pkg::dp_cmd_t   cmd,
  output shapad_pkg::dp_status_t status,
  input  logic [7:0]            data_byte,
  shapad_out_if.source          blk_out
);
  import shapad_pkg::*;

  logic [CountBits-1:0] bit_count, bit_count_next;
  logic [PosBits-1:0]   pos, pos_next;
  logic [23:0]          partial, partial_next;
  logic                 out_valid, out_valid_next;
  logic [WordBits-1:0]  out_word, out_word_next;
  logic                 out_be, out_be_next;
  logic                 out_me, out_me_next;
  logic                 emit;
  logic [WidxBits-1:0]  widx;
  logic [PosBits-1:0]   pos_word_step;
  logic [WordBits-1:0]  sep_word;

  assign widx          = pos[PosBits-1:2];
  assign pos_word_step = {widx + WidxBits'(1), 2'b00};

  // separator closes the word being built
  always_comb begin
    case (pos[1:0])
      2'd0:    sep_word = {PadByte, 24'd0};
      2'd1:    sep_word = {partial[7:0], PadByte, 16'd0};
      2'd2:    sep_word = {partial[15:0], PadByte, 8'd0};
      2'd3:    sep_word = {partial, PadByte};
      default: sep_word = {PadByte, 24'd0};
    endcase
  end

  always_comb begin
    bit_count_next = bit_count;
    pos_next       = pos;
    partial_next   = partial;
    emit           = 1'b0;
    out_word_next  = out_word;
    out_be_next    = out_be;
    out_me_next    = out_me;
    case (cmd.op)
      OP_DATA: begin
        bit_count_next = bit_count + CountBits'(8);
        pos_next       = pos + PosBits'(1);
        if (pos[1:0] == 2'd3) begin
          emit          = 1'b1;
          out_word_next = {partial, data_byte};
          out_be_next   = (widx == LastWordIdx);
          out_me_next   = 1'b0;
        end else begin
          partial_next = {partial[15:0], data_byte};
        end
      end
      OP_SEP: begin
        emit          = 1'b1;
        out_word_next = sep_word;
        out_be_next   = (widx == LastWordIdx);
        out_me_next   = 1'b0;
        pos_next      = pos_word_step;
      end
      OP_FILL: begin
        emit          = 1'b1;
        out_word_next = '0;
        out_be_next   = (widx == LastWordIdx);
        out_me_next   = 1'b0;
        pos_next      = pos_word_step;
      end
      OP_LEN_HI: begin
        emit          = 1'b1;
        out_word_next = bit_count[CountBits-1:WordBits];
        out_be_next   = 1'b0;
        out_me_next   = 1'b0;
        pos_next      = pos_word_step;
      end
      OP_LEN_LO: begin
        emit           = 1'b1;
        out_word_next  = bit_count[WordBits-1:0];
        out_be_next    = 1'b1;
        out_me_next    = 1'b1;
        bit_count_next = '0;
        pos_next       = '0;
        partial_next   = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (blk_out.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= '0;
      pos       <= '0;
      partial   <= '0;
      out_valid <= 1'b0;
    end else begin
      bit_count <= bit_count_next;
      pos       <= pos_next;
      partial   <= partial_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_word_next;
    out_be   <= out_be_next;
    out_me   <= out_me_next;
  end

  assign status.out_free  = !out_valid || blk_out.ready;
  assign status.fill_done = (widx == LastFillIdx);

  assign blk_out.valid       = out_valid;
  assign blk_out.block_word  = out_word;
  assign blk_out.block_end   = out_be;
  assign blk_out.message_end = out_me;

endmodule

### hw/rtl/shapad_ctrl.sv
// Controller of the SHA-256 message padder: takes byte items and sequences
// the padding words. Depends on shapad_pkg.
`timescale 1ns / 1ps

module shapad_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_command,
  output logic                   in_ready,
  input  shapad_pkg::dp_status_t status,
  output shapad_pkg::dp_cmd_t    cmd
);
  import shapad_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          if (in_command == CMD_END) begin
            cmd.op     = OP_SEP;
            state_next = status.fill_done ? ST_LEN_HI : ST_FILL;
          end else begin
            cmd.op = OP_DATA;
          end
        end
      end
      ST_FILL: begin
        if (status.out_free) begin
          cmd.op = OP_FILL;
          if (status.fill_done) begin
            state_next = ST_LEN_HI;
          end
        end
      end
      ST_LEN_HI: begin
        if (status.out_free) begin
          cmd.op     = OP_LEN_HI;
          state_next = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (status.out_free) begin
          cmd.op     = OP_LEN_LO;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/sha256_message_padder.sv
// Channel   Dir  Payload                               Item
// msg_in    in   command[0], data_byte[7:0]            one message byte or end mark
// blk_out   out  block_word[31:0], block_end, message_end  one padded block word
//
// A word leaves every fourth data byte.
// An end mark produces 3 to 18 padding words, set by the controller's fill loop
// through the rest of the block and the two length words; no item is taken meanwhile.
// A stall on blk_out holds both sides; the output register frees as it is taken.
// Synchronous reset clears the count, position and output valid.
// Depends on shapad_pkg, shapad_if, shapad_ctrl, shapad_datapath.
`timescale 1ns / 1ps
`include "sha256_message_padder_assert.svh"

module sha256_message_padder (
  input  logic          clk,
  input  logic          rst,
  shapad_in_if.sink     msg_in,
  shapad_out_if.source  blk_out
);
  import shapad_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  shapad_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg_in.valid),
    .in_command (msg_in.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  shapad_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .data_byte (msg_in.data_byte),
    .blk_out   (blk_out)
  );

  assign msg_in.ready = in_ready;

  // never take an item while the output register is still held
  `SHAPAD_ASSERT_IMP(a_in_needs_room, clk, rst, msg_in.ready,
                     !blk_out.valid || blk_out.ready)
  `SHAPAD_ASSERT_NXT(a_len_lo_ends, clk, rst, cmd.op == OP_LEN_LO,
                     blk_out.valid && blk_out.message_end && blk_out.block_end)
  `SHAPAD_ASSERT_IMP(a_op_needs_room, clk, rst, cmd.op != OP_NONE, status.out_free)

endmodule
